### hdl/stepper_ramp_pulse_generator_defines.svh
// assertion macros for the stepper ramp pulse generator checker
`ifndef STEPPER_RAMP_PULSE_GENERATOR_DEFINES_SVH
`define STEPPER_RAMP_PULSE_GENERATOR_DEFINES_SVH

// same-cycle implication, off during reset
`define SRPG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define SRPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// same-cycle implication that also holds around reset
`define SRPG_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

### hdl/srpg_pkg.sv
// shared types and constants of the stepper ramp pulse generator
`default_nettype none

package srpg_pkg;

  // request codes
  localparam logic [2:0] REQ_TICK = 3'd0;
  localparam logic [2:0] REQ_ADD  = 3'd1;
  localparam logic [2:0] REQ_FWD  = 3'd2;
  localparam logic [2:0] REQ_BWD  = 3'd3;
  localparam logic [2:0] REQ_STOP = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOWEST  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FASTEST  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DELTA    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_FWD_LVL  = 3'd4;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration reset values
  localparam logic [15:0] SLOWEST_RST  = 16'd1000;
  localparam logic [15:0] FASTEST_RST  = 16'd100;
  localparam logic [15:0] INTERVAL_RST = 16'd500;
  localparam logic [15:0] DELTA_RST    = 16'd10;
  localparam logic        FWD_LVL_RST  = 1'b1;

  localparam logic [15:0] PERIOD_MAX = 16'hFFFF;
  localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] step_count;
  } srpg_req_t;

  typedef struct packed {
    logic        step_clock;
    logic        direction;
    logic        running;
    logic        braking;
    logic [31:0] steps_left;
  } srpg_status_t;

endpackage

`default_nettype wire

### hdl/stepper_ramp_pulse_generator.sv
// stepper step/direction generator with trapezoidal speed ramp, top level
//
// usage: each input transaction on in_* carries one request (timebase tick,
// add steps, forward, backward, stop); each produces exactly one status
// transaction on out_* with the pin levels, running and braking flags and
// the remaining step count after that request.
// a transaction moves when valid is high and stall is low.
// each request passes through the input register and then through the
// request logic into the output register, which drives out_valid.
// throughput: one transaction per cycle while the receiver does not stall,
// with the state update done between the input and output registers.
// when the receiver stalls, the status holds in the output register and one
// more request can still be taken into the input register; after that
// in_stall rises until the output drains.
// reset (rst, synchronous) empties both registers, loads the register
// defaults, stops the generator and sets the direction pin to forward.
// configuration writes (wr_en, wr_index, wr_data) are meant for idle times.
`default_nettype none

module stepper_ramp_pulse_generator import srpg_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire srpg_req_t              in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output srpg_status_t                out_data,
  input  wire logic                   wr_en,
  input  wire logic [CFG_INDEX_W-1:0] wr_index,
  input  wire logic [CFG_DATA_W-1:0]  wr_data
);

  // configuration
  logic [15:0] slowest_period;
  logic [15:0] fastest_period;
  logic [15:0] accel_interval;
  logic [15:0] accel_delta;
  logic        forward_level;

  // input register
  logic      s1_valid;
  srpg_req_t s1_data;

  // generator state
  logic [31:0] remaining_steps, remaining_steps_next;
  logic [15:0] period_now, period_now_next;
  logic [15:0] tick_count, tick_count_next;
  logic [15:0] ramp_tick_count, ramp_tick_count_next;
  logic [31:0] ramp_steps, ramp_steps_next;
  logic        half_phase, half_phase_next;
  logic        stop_pending, stop_pending_next;
  logic        reverse_pending, reverse_pending_next;
  logic        active, active_next;
  logic        clock_level, clock_level_next;
  logic        dir_level, dir_level_next;

  logic out_ready;
  logic take;
  logic in_accept;

  assign out_ready = !out_valid || !out_stall;
  assign take      = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      slowest_period <= SLOWEST_RST;
      fastest_period <= FASTEST_RST;
      accel_interval <= INTERVAL_RST;
      accel_delta    <= DELTA_RST;
      forward_level  <= FWD_LVL_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_SLOWEST:  slowest_period <= wr_data;
        CFG_FASTEST:  fastest_period <= wr_data;
        CFG_INTERVAL: accel_interval <= wr_data;
        CFG_DELTA:    accel_delta    <= wr_data;
        CFG_FWD_LVL:  forward_level  <= wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data <= in_data;
    end
  end

  // request logic, follows one request through the generator state
  always_comb begin
    logic [16:0] tick_inc;
    logic [16:0] ramp_inc;
    logic [16:0] grow_sum;
    logic [32:0] add_sum;
    logic        level;

    remaining_steps_next = remaining_steps;
    period_now_next      = period_now;
    tick_count_next      = tick_count;
    ramp_tick_count_next = ramp_tick_count;
    ramp_steps_next      = ramp_steps;
    half_phase_next      = half_phase;
    stop_pending_next    = stop_pending;
    reverse_pending_next = reverse_pending;
    active_next          = active;
    clock_level_next     = clock_level;
    dir_level_next       = dir_level;

    tick_inc = {1'b0, tick_count} + 17'd1;
    ramp_inc = {1'b0, ramp_tick_count} + 17'd1;
    add_sum  = {1'b0, remaining_steps} + {1'b0, s1_data.step_count};
    grow_sum = '0;
    level    = 1'b0;

    unique case (s1_data.req_type) inside
      REQ_TICK: begin
        if (active) begin
          // step clock section
          if (tick_inc >= {1'b0, period_now}) begin
            tick_count_next  = '0;
            clock_level_next = !clock_level;
            if (half_phase) begin
              if (period_now > fastest_period) begin
                if (stop_pending || reverse_pending) begin
                  if (ramp_steps != '0) begin
                    ramp_steps_next = ramp_steps - 32'd1;
                  end
                end else if (ramp_steps != COUNT_MAX) begin
                  ramp_steps_next = ramp_steps + 32'd1;
                end
              end
              if (ramp_steps_next >= remaining_steps) begin
                stop_pending_next = 1'b1;
              end
              if (remaining_steps != '0) begin
                remaining_steps_next = remaining_steps - 32'd1;
              end
              half_phase_next = 1'b0;
            end else begin
              half_phase_next = 1'b1;
            end
            if (remaining_steps_next == '0) begin
              active_next          = 1'b0;
              stop_pending_next    = 1'b0;
              reverse_pending_next = 1'b0;
              remaining_steps_next = '0;
              ramp_steps_next      = '0;
              period_now_next      = slowest_period;
            end
          end else begin
            tick_count_next = tick_inc[15:0];
          end

          // ramp section, runs on the state left by the step clock section
          grow_sum = {1'b0, period_now_next} + {1'b0, accel_delta};
          if (ramp_inc >= {1'b0, accel_interval}) begin
            if (reverse_pending_next) begin
              if (period_now_next < slowest_period) begin
                period_now_next = grow_sum[16] ? PERIOD_MAX : grow_sum[15:0];
              end else begin
                period_now_next      = slowest_period;
                dir_level_next       = !dir_level_next;
                reverse_pending_next = 1'b0;
              end
            end else if (stop_pending_next) begin
              if (period_now_next < slowest_period) begin
                period_now_next = grow_sum[16] ? PERIOD_MAX : grow_sum[15:0];
              end else begin
                active_next          = 1'b0;
                stop_pending_next    = 1'b0;
                reverse_pending_next = 1'b0;
                remaining_steps_next = '0;
                ramp_steps_next      = '0;
                period_now_next      = slowest_period;
              end
            end else if (period_now_next > fastest_period) begin
              period_now_next = (period_now_next > accel_delta) ?
                                period_now_next - accel_delta : '0;
            end
            ramp_tick_count_next = '0;
          end else begin
            ramp_tick_count_next = ramp_inc[15:0];
          end
        end
      end
      REQ_ADD: begin
        remaining_steps_next = add_sum[32] ? COUNT_MAX : add_sum[31:0];
        if (!active && remaining_steps_next != '0) begin
          active_next = 1'b1;
        end
      end
      REQ_FWD, REQ_BWD: begin
        level = (s1_data.req_type == REQ_FWD) ? forward_level : !forward_level;
        if (dir_level != level) begin
          if (remaining_steps != '0) begin
            reverse_pending_next = 1'b1;
          end else begin
            dir_level_next = level;
          end
        end
      end
      REQ_STOP: begin
        stop_pending_next = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining_steps <= '0;
      period_now      <= SLOWEST_RST;
      tick_count      <= '0;
      ramp_tick_count <= '0;
      ramp_steps      <= '0;
      half_phase      <= 1'b0;
      stop_pending    <= 1'b0;
      reverse_pending <= 1'b0;
      active          <= 1'b0;
      clock_level     <= 1'b0;
      dir_level       <= FWD_LVL_RST;
    end else if (take) begin
      remaining_steps <= remaining_steps_next;
      period_now      <= period_now_next;
      tick_count      <= tick_count_next;
      ramp_tick_count <= ramp_tick_count_next;
      ramp_steps      <= ramp_steps_next;
      half_phase      <= half_phase_next;
      stop_pending    <= stop_pending_next;
      reverse_pending <= reverse_pending_next;
      active          <= active_next;
      clock_level     <= clock_level_next;
      dir_level       <= dir_level_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data.step_clock <= clock_level_next;
      out_data.direction  <= dir_level_next;
      out_data.running    <= active_next;
      out_data.braking    <= stop_pending_next;
      out_data.steps_left <= remaining_steps_next;
    end
  end

endmodule

`default_nettype wire

### hdl/srpg_checker.sv
// port-level checker for the stepper ramp pulse generator and its bind
`default_nettype none
`include "stepper_ramp_pulse_generator_defines.svh"

module srpg_checker import srpg_pkg::*; (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         in_stall,
  input wire logic         out_valid,
  input wire logic         out_stall,
  input wire srpg_status_t out_data
);

  // generator runs exactly while steps remain
  `SRPG_ASSERT_NOW(a_run_vs_steps, out_valid, out_data.running == (out_data.steps_left != '0), "running flag disagrees with steps left")

  // input side only backs up when the output register is full and stalled
  `SRPG_ASSERT_NOW(a_stall_cause, !(out_valid && out_stall), !in_stall, "input stalled while output can drain")

  // a held status transaction stays put
  `SRPG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled status transaction changed")

  // nothing comes out right after reset
  `SRPG_ASSERT_ALWAYS(a_reset_empty, $past(rst), !out_valid, "status valid right after reset")

endmodule

bind stepper_ramp_pulse_generator srpg_checker u_srpg_checker (.*);

`default_nettype wire
